/* src/fts_pkg.sv */
// Shared types, constants and helper functions of the fuzzy text match scorer.
package fts_pkg;

  // One input item as it sits in the input register.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       no_byte;
    logic       end_of_text;
  } fts_item_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_QUERY_LENGTH = 2'd0;
  localparam logic [1:0] REG_QUERY_LOW    = 2'd1;
  localparam logic [1:0] REG_QUERY_HIGH   = 2'd2;

  // Score codes.
  localparam logic [6:0] SCORE_PREFIX      = 7'd100;
  localparam logic [6:0] SCORE_INITIALS    = 7'd80;
  localparam logic [6:0] SCORE_SUBSTRING   = 7'd60;
  localparam logic [6:0] SCORE_SUBSEQUENCE = 7'd20;
  localparam logic [6:0] SCORE_NONE        = 7'd0;

  // Word boundary characters.
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_SLASH      = 8'h2F;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_HYPHEN     = 8'h2D;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Folds A-Z to lower case and leaves every other byte alone.
  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic is_boundary(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_SLASH) ||
           (c == CHAR_UNDERSCORE) || (c == CHAR_HYPHEN);
  endfunction

endpackage

/* src/fts_core.sv */
// Match trackers of the scorer: per-text state, one text byte per cycle while take is high.
module fts_core #(
  parameter int QUERY_MAX = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               take,
  input  fts_pkg::fts_item_t                 item,
  input  logic [$clog2(QUERY_MAX+1)-1:0]     query_len,
  input  logic [7:0]                         query_bytes [QUERY_MAX],
  output logic [6:0]                         score
);
  import fts_pkg::*;

  localparam int CW = $clog2(QUERY_MAX + 1);
  localparam int IW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
  localparam logic [CW:0] QMAX_W = (CW + 1)'(QUERY_MAX);
  localparam logic [CW-1:0] QMAX_C = CW'(QUERY_MAX);

  logic [7:0]    window [QUERY_MAX];
  logic [7:0]    window_next [QUERY_MAX];
  logic [CW-1:0] bytes_seen, bytes_seen_next;
  logic          prefix_holds, prefix_holds_next;
  logic          after_boundary, after_boundary_next;
  logic [CW-1:0] initials_seen, initials_seen_next;
  logic          initials_hold, initials_hold_next;
  logic          substring_found, substring_found_next;
  logic [CW-1:0] subseq_index, subseq_index_next;

  logic [7:0]           c;
  logic [7:0]           qf [QUERY_MAX];
  logic [QUERY_MAX-1:0] pos_match;

  always_comb begin
    for (int i = 0; i < QUERY_MAX; i++) begin
      qf[i] = fold(query_bytes[i]);
    end
    c = fold(item.text_byte);
  end

  // The window after this byte is shifted in, compared against the query
  // right-aligned to the newest end.
  always_comb begin
    for (int i = 0; i + 1 < QUERY_MAX; i++) begin
      window_next[i] = window[i + 1];
    end
    window_next[QUERY_MAX - 1] = c;
  end

  always_comb begin
    logic [CW:0] sum;
    logic [CW:0] k;
    for (int j = 0; j < QUERY_MAX; j++) begin
      sum = (CW + 1)'(j) + {1'b0, query_len};
      k   = sum - QMAX_W;
      if (sum >= QMAX_W) begin
        pos_match[j] = (window_next[j] == qf[k[IW-1:0]]);
      end else begin
        pos_match[j] = 1'b1;
      end
    end
  end

  always_comb begin
    bytes_seen_next      = bytes_seen;
    prefix_holds_next    = prefix_holds;
    after_boundary_next  = after_boundary;
    initials_seen_next   = initials_seen;
    initials_hold_next   = initials_hold;
    substring_found_next = substring_found;
    subseq_index_next    = subseq_index;
    score                = SCORE_NONE;

    if (take && !item.no_byte) begin
      if (bytes_seen < query_len && c != qf[bytes_seen[IW-1:0]]) begin
        prefix_holds_next = 1'b0;
      end
      if (is_boundary(c)) begin
        after_boundary_next = 1'b1;
      end else begin
        if (after_boundary) begin
          if (initials_seen < query_len && c != qf[initials_seen[IW-1:0]]) begin
            initials_hold_next = 1'b0;
          end
          if (initials_seen < QMAX_C) begin
            initials_seen_next = initials_seen + 1'b1;
          end
        end
        after_boundary_next = 1'b0;
      end
      if (bytes_seen < QMAX_C) begin
        bytes_seen_next = bytes_seen + 1'b1;
      end
      // Only the newest query_len window bytes are examined, and all of them
      // belong to this text once enough bytes have arrived.
      if (query_len != '0 && bytes_seen_next >= query_len && (&pos_match)) begin
        substring_found_next = 1'b1;
      end
      if (subseq_index < query_len && c == qf[subseq_index[IW-1:0]]) begin
        subseq_index_next = subseq_index + 1'b1;
      end
    end

    if (take && item.end_of_text) begin
      if (query_len != '0 && bytes_seen_next != '0) begin
        if (prefix_holds_next && bytes_seen_next >= query_len) begin
          score = SCORE_PREFIX;
        end else if (initials_hold_next && initials_seen_next >= query_len) begin
          score = SCORE_INITIALS;
        end else if (substring_found_next) begin
          score = SCORE_SUBSTRING;
        end else if (subseq_index_next >= query_len) begin
          score = SCORE_SUBSEQUENCE;
        end
      end
      bytes_seen_next      = '0;
      prefix_holds_next    = 1'b1;
      after_boundary_next  = 1'b1;
      initials_seen_next   = '0;
      initials_hold_next   = 1'b1;
      substring_found_next = 1'b0;
      subseq_index_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !item.no_byte) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen      <= '0;
      prefix_holds    <= 1'b1;
      after_boundary  <= 1'b1;
      initials_seen   <= '0;
      initials_hold   <= 1'b1;
      substring_found <= 1'b0;
      subseq_index    <= '0;
    end else begin
      bytes_seen      <= bytes_seen_next;
      prefix_holds    <= prefix_holds_next;
      after_boundary  <= after_boundary_next;
      initials_seen   <= initials_seen_next;
      initials_hold   <= initials_hold_next;
      substring_found <= substring_found_next;
      subseq_index    <= subseq_index_next;
    end
  end

  a_counts_saturate: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= QMAX_C && initials_seen <= QMAX_C && subseq_index <= QMAX_C)
    else $error("tracker counter beyond its saturation point");

  a_cleared_after_end: assert property (@(posedge clk) disable iff (rst)
    take && item.end_of_text |=> bytes_seen == '0 && subseq_index == '0 &&
    !substring_found && prefix_holds && initials_hold && after_boundary)
    else $error("per-text state not cleared after the last byte");

  a_initials_bounded: assert property (@(posedge clk) disable iff (rst)
    initials_seen <= bytes_seen)
    else $error("more word initials than text bytes");

endmodule

/* src/fuzzy_text_match_scorer.sv */
// Top level of the fuzzy text match scorer: stream ports, query registers, result register.
//
// The block scores a text, streamed one byte per transfer, against a query of up
// to QUERY_MAX bytes held in three configuration registers (length, bytes 0-7,
// bytes 8-15). Bytes are folded to lower case (A-Z only) on both sides. Four
// trackers run side by side on every byte: exact prefix, prefix of the word
// initials (words split at space, slash, underscore and hyphen), contiguous
// substring through a window of the last QUERY_MAX bytes compared in parallel,
// and ordered subsequence. The transfer that carries tlast produces exactly one
// result transfer with score 100, 80, 60, 20 or 0 (in that order of priority);
// an empty query, or a text with no bytes, scores 0. Set tuser on a transfer to
// mark it as carrying no byte, which is how an empty text is sent. The block
// takes one byte per clock cycle sustained: the trackers update from an input
// register, and the result enters the output register when the tlast item
// leaves the input register; it holds in the output register while the next
// text streams in, and input stalls only when a second result is due before the
// first has been taken. Write the configuration only while no text is in flight.
module fuzzy_text_match_scorer #(
  parameter int QUERY_MAX = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tuser,   // [0] no_byte
  input  logic        s_tlast,   // end_of_text
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] match_score, [7] zero
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import fts_pkg::*;

  localparam int CW = $clog2(QUERY_MAX + 1);

  // Configuration registers.
  logic [4:0]  query_length;
  logic [63:0] query_low;
  logic [63:0] query_high;

  logic [CW-1:0] query_len;
  logic [7:0]    query_bytes [QUERY_MAX];

  // Input register.
  logic      in_valid;
  fts_item_t in_item;

  // Result register.
  logic       out_valid;
  logic [6:0] out_score;

  logic       take;
  logic [6:0] score;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_length <= '0;
      query_low    <= '0;
      query_high   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_QUERY_LENGTH: query_length <= cfg_data[4:0];
        REG_QUERY_LOW:    query_low    <= cfg_data;
        REG_QUERY_HIGH:   query_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  // A length above QUERY_MAX counts as QUERY_MAX.
  always_comb begin
    if (query_length > 5'(QUERY_MAX)) begin
      query_len = CW'(QUERY_MAX);
    end else begin
      query_len = CW'(query_length);
    end
    for (int i = 0; i < QUERY_MAX; i++) begin
      if (i < 8) begin
        query_bytes[i] = query_low[(i % 8) * 8 +: 8];
      end else begin
        query_bytes[i] = query_high[(i % 8) * 8 +: 8];
      end
    end
  end

  // The item in the input register moves on unless it would produce a result
  // while the result register is still full.
  assign take     = in_valid && (!in_item.end_of_text || !out_valid || m_tready);
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.text_byte   <= s_tdata;
      in_item.no_byte     <= s_tuser;
      in_item.end_of_text <= s_tlast;
    end
  end

  fts_core #(
    .QUERY_MAX(QUERY_MAX)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .item       (in_item),
    .query_len  (query_len),
    .query_bytes(query_bytes),
    .score      (score)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && in_item.end_of_text) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_item.end_of_text) begin
      out_score <= score;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_score};

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_valid && in_item.end_of_text))
    else $error("result produced without a last byte");

  a_legal_score: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_score == SCORE_PREFIX || out_score == SCORE_INITIALS ||
                  out_score == SCORE_SUBSTRING || out_score == SCORE_SUBSEQUENCE ||
                  out_score == SCORE_NONE))
    else $error("score outside the legal set");

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !take |=> in_valid && $stable(in_item))
    else $error("stalled input item lost");

endmodule
